### rtl/core/relativistic_verlet_position_push_macros.svh
// assertion helpers for the position push core
`ifndef RELATIVISTIC_VERLET_POSITION_PUSH_MACROS_SVH
`define RELATIVISTIC_VERLET_POSITION_PUSH_MACROS_SVH

`ifndef SYNTHESIS
`define RVPP_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rvpp check failed");
`define RVPP_ASSERT_NR(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("rvpp check failed");
`else
`define RVPP_ASSERT(name, clk, rst, prop)
`define RVPP_ASSERT_NR(name, clk, prop)
`endif

`endif

### rtl/core/rvpp_pkg.sv
package rvpp_pkg;

  localparam int IN_W       = 384;
  localparam int OUT_W      = 96;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;
  localparam int SQ_STEPS   = 32;
  localparam int DIV_STEPS  = 33;

  localparam logic [16:0] COURANT_RST = 17'd29491;
  localparam logic [1:0]  CHARGE_RST  = 2'b01;
  localparam logic [40:0] MAG_CAP     = 41'h100_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COURANT = 1'b0,
    REG_CHARGE  = 1'b1
  } cfg_reg_t;

  // per-particle values that ride along the pipeline
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] mu;
    logic [2:0]       nu;
    logic [2:0][31:0] ef;
    logic [2:0][63:0] mc;
    logic [2:0]       nc;
    logic [2:0][40:0] mv;
    logic [2:0]       an;
  } wk_t;

endpackage

### rtl/core/relativistic_verlet_position_push.sv
// channel  dir  bits  content
// s_*      in   384   word: pos_x,y,z, mom_x,y,z, efield_x,y,z, bfield_x,y,z
// m_*      out  96    word: new_pos_x, new_pos_y, new_pos_z
// cfg_*    in   17    register write, index 0 courant_number, 1 charge_sign
//
// one particle per cycle while the output is not stalled: 32 square root stages and
// 33 divider stages make up most of the pipeline, the rest are multiply and round stages
// rst clears the valid line and loads the register defaults
// a stall at the output freezes the whole pipeline; s_tready follows it
`include "relativistic_verlet_position_push_macros.svh"

module relativistic_verlet_position_push #(
  parameter int DIMS = 3
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // pos_x, pos_y, pos_z, mom_x, mom_y, mom_z, efield_x..z, bfield_x..z
  input  logic [rvpp_pkg::IN_W-1:0]        s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // new_pos_x, new_pos_y, new_pos_z
  output logic [rvpp_pkg::OUT_W-1:0]       m_tdata,
  input  logic                             cfg_we,
  input  logic [rvpp_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [rvpp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rvpp_pkg::*;

  localparam int LAT = 2 + SQ_STEPS + DIV_STEPS + 9;
  localparam int NXT [3] = '{1, 2, 0};
  localparam int PRV [3] = '{2, 0, 1};

  logic [16:0] courant;
  logic [1:0]  charge;
  logic [33:0] c2;
  logic        en;
  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      courant <= COURANT_RST;
      charge  <= CHARGE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_COURANT: courant <= cfg_data;
        REG_CHARGE:  charge  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    c2 <= 34'(courant) * 34'(courant);
  end

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // stage 1: squares and cross products
  logic signed [31:0] in_u [3];
  logic signed [31:0] in_b [3];
  logic [31:0]        in_mu [3];
  logic [63:0]        st1_sq [3];
  logic signed [63:0] st1_pa [3];
  logic signed [63:0] st1_pb [3];
  wk_t                st1_wk;
  wk_t                st1_wk_next;

  always_comb begin
    st1_wk_next = '0;
    for (int i = 0; i < 3; i++) begin
      in_u[i]  = s_tdata[(3 + i) * 32 +: 32];
      in_b[i]  = s_tdata[(9 + i) * 32 +: 32];
      in_mu[i] = in_u[i][31] ? 32'(-in_u[i]) : in_u[i];
      st1_wk_next.pos[i] = s_tdata[i * 32 +: 32];
      st1_wk_next.mu[i]  = in_mu[i];
      st1_wk_next.nu[i]  = in_u[i][31];
      st1_wk_next.ef[i]  = s_tdata[(6 + i) * 32 +: 32];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1_wk <= st1_wk_next;
      for (int i = 0; i < 3; i++) begin
        st1_sq[i]        <= 64'(in_mu[i]) * 64'(in_mu[i]);
        st1_pa[i]        <= 64'(in_u[NXT[i]]) * 64'(in_b[PRV[i]]);
        st1_pb[i]        <= 64'(in_u[PRV[i]]) * 64'(in_b[NXT[i]]);
      end
    end
  end

  // stage 2: 1 + |u|^2 and cross magnitudes
  logic signed [64:0] cr_d [3];
  logic [64:0]        cr_n [3];
  logic [63:0]        s2_s;
  wk_t                s2_wk;
  wk_t                s2_wk_next;

  always_comb begin
    s2_wk_next = st1_wk;
    for (int i = 0; i < 3; i++) begin
      cr_d[i] = {st1_pa[i][63], st1_pa[i]} - {st1_pb[i][63], st1_pb[i]};
      cr_n[i] = 65'(-cr_d[i]);
      s2_wk_next.mc[i] = cr_d[i][64] ? cr_n[i][63:0] : cr_d[i][63:0];
      s2_wk_next.nc[i] = cr_d[i][64];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_s  <= st1_sq[0] + st1_sq[1] + st1_sq[2] + 64'h1_0000_0000;
      s2_wk <= s2_wk_next;
    end
  end

  // integer square root, one result bit per stage
  logic [33:0] sr_rem  [SQ_STEPS];
  logic [31:0] sr_root [SQ_STEPS];
  logic [63:0] sr_s    [SQ_STEPS];
  wk_t         sr_wk   [SQ_STEPS];

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sq
    logic [33:0] rem_i;
    logic [31:0] root_i;
    logic [63:0] s_i;
    wk_t         wk_i;
    logic [35:0] cat;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        ge;
    if (j == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign s_i    = s2_s;
      assign wk_i   = s2_wk;
    end else begin : g_next
      assign rem_i  = sr_rem[j-1];
      assign root_i = sr_root[j-1];
      assign s_i    = sr_s[j-1];
      assign wk_i   = sr_wk[j-1];
    end
    assign cat   = {rem_i, s_i[2 * (SQ_STEPS - 1 - j) + 1 -: 2]};
    assign trial = {2'b00, root_i, 2'b01};
    assign ge    = cat >= trial;
    assign diff  = cat - trial;
    always_ff @(posedge clk) begin
      if (en) begin
        sr_rem[j]  <= ge ? diff[33:0] : cat[33:0];
        sr_root[j] <= {root_i[30:0], ge};
        sr_s[j]    <= s_i;
        sr_wk[j]   <= wk_i;
      end
    end
  end

  // 2^48 / t, one quotient bit per stage; upper bits are known zero
  logic [31:0] dv_rem [DIV_STEPS];
  logic [32:0] dv_q   [DIV_STEPS];
  logic [31:0] dv_t   [DIV_STEPS];
  wk_t         dv_wk  [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_dv
    logic [31:0] rem_i;
    logic [32:0] q_i;
    logic [31:0] t_i;
    wk_t         wk_i;
    logic [32:0] r2;
    logic [32:0] diff;
    logic        ge;
    if (j == 0) begin : g_first
      assign rem_i = 32'h0000_8000;
      assign q_i   = '0;
      assign t_i   = sr_root[SQ_STEPS-1];
      assign wk_i  = sr_wk[SQ_STEPS-1];
    end else begin : g_next
      assign rem_i = dv_rem[j-1];
      assign q_i   = dv_q[j-1];
      assign t_i   = dv_t[j-1];
      assign wk_i  = dv_wk[j-1];
    end
    assign r2   = {rem_i, 1'b0};
    assign ge   = r2 >= {1'b0, t_i};
    assign diff = r2 - {1'b0, t_i};
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[j] <= ge ? diff[31:0] : r2[31:0];
        dv_q[j]   <= {q_i[31:0], ge};
        dv_t[j]   <= t_i;
        dv_wk[j]  <= wk_i;
      end
    end
  end

  logic [32:0] g_val;
  assign g_val = dv_q[DIV_STEPS-1];

  // m1: products with g, cross split in two halves
  logic [64:0] m1_pm [3];
  logic [64:0] m1_lo [3];
  logic [64:0] m1_hi [3];
  wk_t         m1_wk;

  always_ff @(posedge clk) begin
    if (en) begin
      m1_wk <= dv_wk[DIV_STEPS-1];
      for (int i = 0; i < 3; i++) begin
        m1_pm[i] <= 65'(dv_wk[DIV_STEPS-1].mu[i]) * 65'(g_val);
        m1_lo[i] <= 65'(dv_wk[DIV_STEPS-1].mc[i][31:0]) * 65'(g_val);
        m1_hi[i] <= 65'(dv_wk[DIV_STEPS-1].mc[i][63:32]) * 65'(g_val);
      end
    end
  end

  // m2: times c, join cross halves
  logic [81:0] m2_mvp [3];
  logic [96:0] m2_gcp [3];
  wk_t         m2_wk;

  always_ff @(posedge clk) begin
    if (en) begin
      m2_wk <= m1_wk;
      for (int i = 0; i < 3; i++) begin
        m2_mvp[i] <= 82'(m1_pm[i]) * 82'(courant);
        m2_gcp[i] <= {m1_hi[i], 32'b0} + {32'b0, m1_lo[i]};
      end
    end
  end

  // m3: round and cap
  logic [82:0]        tm_mv [3];
  logic [97:0]        tm_gc [3];
  logic [65:0]        gc_r  [3];
  logic [40:0]        gc_m  [3];
  logic signed [41:0] m3_gc [3];
  wk_t                m3_wk;
  wk_t                m3_wk_next;

  always_comb begin
    m3_wk_next = m2_wk;
    for (int i = 0; i < 3; i++) begin
      tm_mv[i] = {1'b0, m2_mvp[i]} + (83'd1 << 47);
      tm_gc[i] = {1'b0, m2_gcp[i]} + (98'd1 << 31);
      gc_r[i]  = tm_gc[i][97:32];
      gc_m[i]  = (gc_r[i] > 66'(MAG_CAP)) ? MAG_CAP : gc_r[i][40:0];
      // move acts only on the leading axes
      m3_wk_next.mv[i] = (i < DIMS) ? {6'b0, tm_mv[i][82:48]} : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3_wk <= m3_wk_next;
      for (int i = 0; i < 3; i++) begin
        m3_gc[i]    <= m2_wk.nc[i] ? -$signed({1'b0, gc_m[i]}) : $signed({1'b0, gc_m[i]});
      end
    end
  end

  // m4: a = e * 2^16 + g * cross
  logic signed [48:0] m4_a [3];
  wk_t                m4_wk;

  always_ff @(posedge clk) begin
    if (en) begin
      m4_wk <= m3_wk;
      for (int i = 0; i < 3; i++) begin
        m4_a[i] <= $signed({m3_wk.ef[i][31], m3_wk.ef[i], 16'b0}) +
                   $signed({{7{m3_gc[i][41]}}, m3_gc[i]});
      end
    end
  end

  // m5: magnitude of a
  logic [48:0] a_n  [3];
  logic [47:0] m5_ma [3];
  wk_t         m5_wk;
  wk_t         m5_wk_next;

  always_comb begin
    m5_wk_next = m4_wk;
    for (int i = 0; i < 3; i++) begin
      a_n[i] = 49'(-m4_a[i]);
      m5_wk_next.an[i] = m4_a[i][48];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m5_wk <= m5_wk_next;
      for (int i = 0; i < 3; i++) begin
        m5_ma[i]    <= m4_a[i][48] ? a_n[i][47:0] : m4_a[i][47:0];
      end
    end
  end

  // m6, m7: |a| * c^2 in two partial products
  logic [57:0] m6_lo [3];
  logic [57:0] m6_hi [3];
  wk_t         m6_wk;
  logic [81:0] m7_fp [3];
  wk_t         m7_wk;

  always_ff @(posedge clk) begin
    if (en) begin
      m6_wk <= m5_wk;
      m7_wk <= m6_wk;
      for (int i = 0; i < 3; i++) begin
        m6_lo[i] <= 58'(m5_ma[i][23:0]) * 58'(c2);
        m6_hi[i] <= 58'(m5_ma[i][47:24]) * 58'(c2);
        m7_fp[i] <= {m6_hi[i], 24'b0} + {24'b0, m6_lo[i]};
      end
    end
  end

  // m8: round force
  logic [82:0] tm_f [3];
  logic [33:0] m8_f [3];
  wk_t         m8_wk;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tm_f[i] = {1'b0, m7_fp[i]} + (83'd1 << 48);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m8_wk <= m7_wk;
      for (int i = 0; i < 3; i++) begin
        m8_f[i] <= tm_f[i][82:49];
      end
    end
  end

  // m9: sum and clamp into the output word
  logic signed [39:0] smv   [3];
  logic signed [39:0] sfc   [3];
  logic signed [39:0] total [3];
  logic [31:0]        out_pos [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      smv[i] = m8_wk.nu[i] ? -$signed({1'b0, m8_wk.mv[i][38:0]})
                           : $signed({1'b0, m8_wk.mv[i][38:0]});
      if (charge == 2'b00) begin
        sfc[i] = '0;
      end else if (m8_wk.an[i] ^ charge[1]) begin
        sfc[i] = -$signed({6'b0, m8_f[i]});
      end else begin
        sfc[i] = $signed({6'b0, m8_f[i]});
      end
      total[i] = $signed({{8{m8_wk.pos[i][31]}}, m8_wk.pos[i]}) + smv[i] + sfc[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (total[i] > 40'sd2147483647) begin
          out_pos[i] <= 32'h7FFF_FFFF;
        end else if (total[i] < -40'sd2147483648) begin
          out_pos[i] <= 32'h8000_0000;
        end else begin
          out_pos[i] <= total[i][31:0];
        end
      end
    end
  end

  assign m_tdata = {out_pos[2], out_pos[1], out_pos[0]};

  `RVPP_ASSERT_NR(a_rst_empty, clk, $past(rst) |-> !m_tvalid)
  `RVPP_ASSERT(a_stall_hold, clk, rst, !en |=> $stable(vld))
  `RVPP_ASSERT(a_root_min, clk, rst, vld[1 + SQ_STEPS] |-> sr_root[SQ_STEPS-1] >= 32'h0001_0000)
  `RVPP_ASSERT(a_g_max, clk, rst, vld[1 + SQ_STEPS + DIV_STEPS] |-> g_val <= 33'h1_0000_0000)

endmodule
